FILE: design/sha1md_pkg.sv
// Shared types, constants and initial-value table for the SHA-1 digest block.
package sha1md_pkg;

    localparam int H_WORDS   = 5;
    localparam int BLK_WORDS = 16;
    localparam int ROUNDS    = 80;
    localparam int RAM_DEPTH = 32;
    localparam int RAM_AW    = 5;

    localparam logic [RAM_AW-1:0] H_BASE   = 5'd16;
    localparam logic [7:0]        PAD_BYTE = 8'h80;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       byte_present;
        logic       end_of_message;
    } msg_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } dig_t;

    typedef struct packed {
        logic       shift;
        logic       round;
        logic [6:0] round_idx;
    } core_cmd_t;

    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] waddr;
        logic [31:0]       wdata;
        logic [RAM_AW-1:0] raddr;
    } ram_req_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PAD   = 7'b0000010,
        ST_HLOAD = 7'b0000100,
        ST_ROUND = 7'b0001000,
        ST_HADD  = 7'b0010000,
        ST_OREAD = 7'b0100000,
        ST_OCAP  = 7'b1000000
    } state_t;

    function automatic logic [31:0] h_init(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0:    v = H0_INIT;
            3'd1:    v = H1_INIT;
            3'd2:    v = H2_INIT;
            3'd3:    v = H3_INIT;
            3'd4:    v = H4_INIT;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/sha1md_ram.sv
// Generic one-write, one-read synchronous RAM with registered read data.
module sha1md_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/sha1md_core.sv
// SHA-1 round datapath: working variables a..e and the 16-word schedule window.
module sha1md_core (
    input  logic                  clk,
    input  sha1md_pkg::core_cmd_t cmd,
    input  logic [31:0]           data_in,
    output logic [31:0]           a_word
);

    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] w_reg [sha1md_pkg::BLK_WORDS];
    logic [31:0] w_mix, w_t, f_val, k_val, t_val;

    always_comb
    begin
        w_mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_t   = (cmd.round_idx < 7'd16) ? data_in : {w_mix[30:0], w_mix[31]};
        if (cmd.round_idx < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1md_pkg::K0;
        end
        else if (cmd.round_idx < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1md_pkg::K1;
        end
        else if (cmd.round_idx < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1md_pkg::K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1md_pkg::K3;
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_t;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.round)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
            for (int i = 0; i < sha1md_pkg::BLK_WORDS - 1; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[sha1md_pkg::BLK_WORDS-1] <= w_t;
        end
        else if (cmd.shift)
        begin
            a_reg <= b_reg;
            b_reg <= c_reg;
            c_reg <= d_reg;
            d_reg <= e_reg;
            e_reg <= data_in;
        end
    end

    assign a_word = a_reg;

endmodule

FILE: design/sha1md_top.sv
// SHA-1 digest engine: byte intake, padding, compression sequencing, digest output.
//
// Input channel msg: one transfer per message byte (byte_present) with an
// end_of_message flag; an end transfer without a byte closes the message as is.
// Output channel dig: five transfers per message, h0..h4, last_word on h4.
// Block words and chaining words share one 32-entry RAM (block at 0..15,
// chaining at 16..20) with registered read data. When a block fills,
// compression reads the chaining words into the working variables, runs 80
// rounds fed from the RAM port and the schedule window, then reads, adds and
// writes back the chaining words. After an end transfer the pad bytes go in
// at one per cycle, pausing while each filled block is compressed; the final
// block is then compressed, and each digest word is read from the RAM and
// then loaded into the output register.
// msg_ready is low while padding, compressing or emitting the digest, and
// output words wait in the register while dig_ready is low. The next message
// is taken while the last digest word still waits.
// Reset (rst_n low, asynchronous) clears the byte count and bit length and
// marks the chaining words as holding the initial values; no RAM sweep needed.
module sha1_message_digest_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              msg_valid,
    output logic              msg_ready,
    input  sha1md_pkg::msg_t  msg,
    output logic              dig_valid,
    input  logic              dig_ready,
    output sha1md_pkg::dig_t  dig
);

    sha1md_pkg::state_t    state_reg, state_next;
    logic [6:0]            cnt_reg, cnt_next;
    logic [5:0]            bytes_reg, bytes_next;
    logic [60:0]           len_reg, len_next;
    logic [23:0]           wacc_reg, wacc_next;
    logic                  sent80_reg, sent80_next;
    logic [3:0]            lcnt_reg, lcnt_next;
    logic                  pad_reg, pad_next;
    logic [sha1md_pkg::H_WORDS-1:0] hv_reg, hv_next;
    logic [2:0]            rd_hidx_reg;
    logic                  dig_valid_reg, dig_valid_next;
    sha1md_pkg::dig_t      dig_reg, dig_next;

    sha1md_pkg::ram_req_t  req;
    sha1md_pkg::core_cmd_t cmd;
    logic [31:0]           rd_data, core_a, core_din, hval;
    logic                  hv_sel;
    logic                  put_en;
    logic [7:0]            put_b;
    logic [63:0]           bitlen;
    logic [2:0]            lsel;

    sha1md_ram #(
        .DEPTH(sha1md_pkg::RAM_DEPTH),
        .WIDTH(32)
    ) u_ram (
        .clk   (clk),
        .we    (req.we),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .raddr (req.raddr),
        .rdata (rd_data)
    );

    sha1md_core u_core (
        .clk     (clk),
        .cmd     (cmd),
        .data_in (core_din),
        .a_word  (core_a)
    );

    always_comb
    begin
        hv_sel = 1'b0;
        for (int i = 0; i < sha1md_pkg::H_WORDS; i++)
        begin
            if (rd_hidx_reg == 3'(i))
            begin
                hv_sel = hv_reg[i];
            end
        end
        hval     = hv_sel ? rd_data : sha1md_pkg::h_init(rd_hidx_reg);
        core_din = (state_reg == sha1md_pkg::ST_ROUND) ? rd_data : hval;
        bitlen   = {len_reg, 3'b000};
        lsel     = 3'd7 - lcnt_reg[2:0];
    end

    assign msg_ready = (state_reg == sha1md_pkg::ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        bytes_next     = bytes_reg;
        len_next       = len_reg;
        wacc_next      = wacc_reg;
        sent80_next    = sent80_reg;
        lcnt_next      = lcnt_reg;
        pad_next       = pad_reg;
        hv_next        = hv_reg;
        dig_valid_next = dig_valid_reg && !dig_ready;
        dig_next       = dig_reg;
        req            = '0;
        cmd            = '0;
        put_en         = 1'b0;
        put_b          = 8'h00;

        unique case (state_reg)
            sha1md_pkg::ST_IDLE:
            begin
                if (msg_valid)
                begin
                    put_en = msg.byte_present;
                    put_b  = msg.message_byte;
                    if (msg.byte_present)
                    begin
                        len_next = len_reg + 61'd1;
                    end
                    if (msg.end_of_message)
                    begin
                        pad_next   = 1'b1;
                        state_next = sha1md_pkg::ST_PAD;
                    end
                end
            end
            sha1md_pkg::ST_PAD:
            begin
                put_en = 1'b1;
                if (!sent80_reg)
                begin
                    put_b       = sha1md_pkg::PAD_BYTE;
                    sent80_next = 1'b1;
                end
                else if (lcnt_reg == 4'd0 && bytes_reg != 6'd56)
                begin
                    put_b = 8'h00;
                end
                else
                begin
                    put_b     = 8'(bitlen >> {lsel, 3'b000});
                    lcnt_next = lcnt_reg + 4'd1;
                end
            end
            sha1md_pkg::ST_HLOAD:
            begin
                req.raddr = (cnt_reg < 7'd5) ? sha1md_pkg::H_BASE + 5'(cnt_reg) : 5'd0;
                cmd.shift = (cnt_reg != 7'd0);
                if (cnt_reg == 7'd5)
                begin
                    state_next = sha1md_pkg::ST_ROUND;
                    cnt_next   = 7'd0;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            sha1md_pkg::ST_ROUND:
            begin
                cmd.round     = 1'b1;
                cmd.round_idx = cnt_reg;
                req.raddr     = {1'b0, 4'(cnt_reg + 7'd1)};
                if (cnt_reg == 7'(sha1md_pkg::ROUNDS - 1))
                begin
                    state_next = sha1md_pkg::ST_HADD;
                    cnt_next   = 7'd0;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            sha1md_pkg::ST_HADD:
            begin
                if (cnt_reg < 7'd5)
                begin
                    req.raddr = sha1md_pkg::H_BASE + 5'(cnt_reg);
                end
                if (cnt_reg != 7'd0)
                begin
                    req.we    = 1'b1;
                    req.waddr = sha1md_pkg::H_BASE + {2'b00, rd_hidx_reg};
                    req.wdata = hval + core_a;
                    cmd.shift = 1'b1;
                    for (int i = 0; i < sha1md_pkg::H_WORDS; i++)
                    begin
                        if (rd_hidx_reg == 3'(i))
                        begin
                            hv_next[i] = 1'b1;
                        end
                    end
                end
                if (cnt_reg == 7'd5)
                begin
                    cnt_next = 7'd0;
                    if (lcnt_reg == 4'd8)
                    begin
                        state_next = sha1md_pkg::ST_OREAD;
                    end
                    else if (pad_reg)
                    begin
                        state_next = sha1md_pkg::ST_PAD;
                    end
                    else
                    begin
                        state_next = sha1md_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            sha1md_pkg::ST_OREAD:
            begin
                if (!dig_valid_reg || dig_ready)
                begin
                    req.raddr  = sha1md_pkg::H_BASE + 5'(cnt_reg);
                    state_next = sha1md_pkg::ST_OCAP;
                end
            end
            sha1md_pkg::ST_OCAP:
            begin
                dig_next.digest_word = hval;
                dig_next.word_number = cnt_reg[2:0];
                dig_next.last_word   = (cnt_reg == 7'd4);
                dig_valid_next       = 1'b1;
                if (cnt_reg == 7'd4)
                begin
                    state_next  = sha1md_pkg::ST_IDLE;
                    cnt_next    = 7'd0;
                    hv_next     = '0;
                    len_next    = '0;
                    sent80_next = 1'b0;
                    lcnt_next   = 4'd0;
                    pad_next    = 1'b0;
                end
                else
                begin
                    cnt_next   = cnt_reg + 7'd1;
                    state_next = sha1md_pkg::ST_OREAD;
                end
            end
            default:
            begin
                state_next = sha1md_pkg::ST_IDLE;
            end
        endcase

        // byte store: assemble big-endian words, write on the fourth byte
        if (put_en)
        begin
            bytes_next = bytes_reg + 6'd1;
            unique case (bytes_reg[1:0])
                2'd0: wacc_next = {put_b, 16'h0000};
                2'd1: wacc_next = {wacc_reg[23:16], put_b, 8'h00};
                2'd2: wacc_next = {wacc_reg[23:8], put_b};
                2'd3:
                begin
                    req.we    = 1'b1;
                    req.waddr = {1'b0, bytes_reg[5:2]};
                    req.wdata = {wacc_reg, put_b};
                end
            endcase
            if (bytes_reg == 6'd63)
            begin
                state_next = sha1md_pkg::ST_HLOAD;
                cnt_next   = 7'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha1md_pkg::ST_IDLE;
            cnt_reg       <= 7'd0;
            bytes_reg     <= 6'd0;
            len_reg       <= '0;
            sent80_reg    <= 1'b0;
            lcnt_reg      <= 4'd0;
            pad_reg       <= 1'b0;
            hv_reg        <= '0;
            rd_hidx_reg   <= 3'd0;
            dig_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            bytes_reg     <= bytes_next;
            len_reg       <= len_next;
            sent80_reg    <= sent80_next;
            lcnt_reg      <= lcnt_next;
            pad_reg       <= pad_next;
            hv_reg        <= hv_next;
            rd_hidx_reg   <= req.raddr[2:0];
            dig_valid_reg <= dig_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wacc_reg <= wacc_next;
        dig_reg  <= dig_next;
    end

    assign dig_valid = dig_valid_reg;
    assign dig       = dig_reg;

`ifndef SYNTH
    a_hload_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sha1md_pkg::ST_HLOAD |-> bytes_reg == 6'd0)
        else $error("compression started with bytes pending");

    a_ocap_padded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sha1md_pkg::ST_OCAP |-> lcnt_reg == 4'd8)
        else $error("digest output before length was stored");

    a_put_block_area: assert property (@(posedge clk) disable iff (!rst_n)
        req.we && (state_reg == sha1md_pkg::ST_IDLE || state_reg == sha1md_pkg::ST_PAD)
        |-> !req.waddr[4])
        else $error("byte write hit chaining words");

    a_end_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && msg.end_of_message |=> state_reg != sha1md_pkg::ST_IDLE)
        else $error("end transfer did not start padding");

    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && dig.last_word |-> dig.word_number == 3'd4)
        else $error("last word flag on wrong digest word");
`endif

endmodule
